// ----- src/jmsi_pkg.sv -----
// shared types, marker codes and helpers for the jpeg marker segment indexer
package jmsi_pkg;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_FILL   = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_SKIP   = 3'd4,
    PH_STOP   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_DHT  = 3'd1,
    KIND_DQT  = 3'd2,
    KIND_SOF0 = 3'd3,
    KIND_SOS  = 3'd4,
    KIND_APP1 = 3'd5
  } kind_t;

  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_STUFF  = 8'h00;
  localparam logic [7:0] CODE_DHT    = 8'hC4;
  localparam logic [7:0] CODE_DQT    = 8'hDB;
  localparam logic [7:0] CODE_SOF0   = 8'hC0;
  localparam logic [7:0] CODE_SOS    = 8'hDA;
  localparam logic [7:0] CODE_APP1   = 8'hE1;

  localparam int unsigned OUT_BITS     = 24;
  localparam int unsigned MARK_TO_DATA = 3;

  function automatic kind_t classify(input logic [7:0] code);
    kind_t k;
    case (code)
      CODE_DHT:  k = KIND_DHT;
      CODE_DQT:  k = KIND_DQT;
      CODE_SOF0: k = KIND_SOF0;
      CODE_SOS:  k = KIND_SOS;
      CODE_APP1: k = KIND_APP1;
      default:   k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

// ----- src/jpeg_marker_segment_indexer_top.sv -----
// jpeg marker segment indexer: scans one frame a word at a time, reports segment offsets
//
// usage
//   input channel  in_valid/in_stall carries one frame byte per word with
//   in_last_byte marking the final byte and in_write_next sampled with it.
//   result channel out_valid/out_stall carries one offsets record per frame.
//   config channel cfg_valid/cfg_ready writes length_kludge_mode; cfg_ready
//   is always high, write only while the block is idle.
// throughput: one word per cycle unless a last byte is held off, set by the parse state update
// output: the record is registered and appears in the cycle after the last byte is accepted
// stall: bytes that are not last keep flowing while a record waits; a last
//   byte is held off only while the previous record is still stalled
// reset: parse state, all offsets and the mode clear, no record pending;
//   after each record the parse state clears for the next frame
module jpeg_marker_segment_indexer_top #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        in_write_next,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_frame_size,
  output logic [23:0] out_next_field_offset,
  output logic [23:0] out_quant_table_offset,
  output logic [23:0] out_huffman_table_offset,
  output logic [23:0] out_frame_header_offset,
  output logic [23:0] out_scan_header_offset,
  output logic [23:0] out_scan_data_offset,
  output logic [23:0] out_app1_payload_offset,
  output logic        out_app1_found,
  output logic        out_scan_found,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import jmsi_pkg::*;

  localparam int unsigned P = POSITION_BITS;

  function automatic logic [P-1:0] sat_add(input logic [P-1:0] a, input logic [P-1:0] b);
    logic [P:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[P] ? {P{1'b1}} : s[P-1:0];
  endfunction

  function automatic logic [OUT_BITS-1:0] clamp(input logic [P-1:0] v);
    logic [P+OUT_BITS-1:0] ext;
    ext = {{OUT_BITS{1'b0}}, v};
    if (ext > (P+OUT_BITS)'({OUT_BITS{1'b1}})) return {OUT_BITS{1'b1}};
    return ext[OUT_BITS-1:0];
  endfunction

  logic            kludge_r;
  phase_t          phase_r, phase_nxt;
  kind_t           kind_r, kind_nxt, kind_c;
  logic [P-1:0]    pos_r, pos_nxt;
  logic [P-1:0]    mark3_r, mark3_nxt;
  logic [7:0]      len_hi_r, len_hi_nxt;
  logic [15:0]     skip_r, skip_nxt;
  logic [P-1:0]    quant_r, quant_nxt, huff_r, huff_nxt, frame_r, frame_nxt;
  logic [P-1:0]    scan_r, scan_nxt, data_r, data_nxt, app1_r, app1_nxt;
  logic            app1_seen_r, app1_seen_nxt, scan_seen_r, scan_seen_nxt;
  logic [P-1:0]    pos_m1, pos_p3;
  logic [15:0]     seglen, skip_c;
  logic            in_acc, out_acc;

  logic            out_valid_r;
  logic [23:0]     size_r, next_r, oquant_r, ohuff_r, oframe_r, oscan_r, odata_r, oapp1_r;
  logic            oapp1_found_r, oscan_found_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall & in_last_byte;
  assign in_acc    = in_valid & ~in_stall;
  assign out_acc   = out_valid_r & ~out_stall;

  assign pos_m1 = pos_r - P'(1);
  assign pos_p3 = sat_add(pos_r, P'(MARK_TO_DATA));
  assign seglen = {len_hi_r, in_data_byte};
  assign skip_c = (kludge_r && kind_r != KIND_APP1) ? seglen :
                  (seglen >= 16'd2) ? seglen - 16'd2 : 16'd0;
  assign kind_c = classify(in_data_byte);

  always_comb begin
    phase_nxt     = phase_r;
    kind_nxt      = kind_r;
    mark3_nxt     = mark3_r;
    len_hi_nxt    = len_hi_r;
    skip_nxt      = skip_r;
    quant_nxt     = quant_r;
    huff_nxt      = huff_r;
    frame_nxt     = frame_r;
    scan_nxt      = scan_r;
    data_nxt      = data_r;
    app1_nxt      = app1_r;
    app1_seen_nxt = app1_seen_r;
    scan_seen_nxt = scan_seen_r;
    pos_nxt       = sat_add(pos_r, P'(1));
    case (phase_r)
      PH_HUNT: begin
        if (in_data_byte == MARK_PREFIX) phase_nxt = PH_FILL;
      end
      PH_FILL: begin
        if (in_data_byte == MARK_PREFIX) begin
          phase_nxt = PH_FILL;
        end else if (in_data_byte == MARK_STUFF) begin
          phase_nxt = PH_HUNT;
        end else begin
          kind_nxt = kind_c;
          if (kind_c == KIND_NONE) begin
            phase_nxt = PH_HUNT;
          end else begin
            mark3_nxt = pos_p3;
            phase_nxt = PH_LEN_HI;
            case (kind_c)
              KIND_DHT:  huff_nxt  = pos_m1;
              KIND_DQT:  quant_nxt = pos_m1;
              KIND_SOF0: frame_nxt = pos_m1;
              KIND_SOS:  scan_nxt  = pos_m1;
              KIND_APP1: begin
                app1_nxt      = pos_p3;
                app1_seen_nxt = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end
      PH_LEN_HI: begin
        len_hi_nxt = in_data_byte;
        phase_nxt  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (kind_r == KIND_SOS) begin
          data_nxt      = sat_add(mark3_r, P'(skip_c));
          scan_seen_nxt = 1'b1;
          phase_nxt     = PH_STOP;
        end else begin
          skip_nxt  = skip_c;
          phase_nxt = (skip_c != 16'd0) ? PH_SKIP : PH_HUNT;
        end
      end
      PH_SKIP: begin
        if (skip_r <= 16'd1) begin
          skip_nxt  = 16'd0;
          phase_nxt = PH_HUNT;
        end else begin
          skip_nxt = skip_r - 16'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kludge_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      kludge_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && in_last_byte)) begin
      phase_r     <= PH_HUNT;
      kind_r      <= KIND_NONE;
      pos_r       <= '0;
      mark3_r     <= '0;
      len_hi_r    <= '0;
      skip_r      <= '0;
      quant_r     <= '0;
      huff_r      <= '0;
      frame_r     <= '0;
      scan_r      <= '0;
      data_r      <= '0;
      app1_r      <= '0;
      app1_seen_r <= 1'b0;
      scan_seen_r <= 1'b0;
    end else if (in_acc) begin
      phase_r     <= phase_nxt;
      kind_r      <= kind_nxt;
      pos_r       <= pos_nxt;
      mark3_r     <= mark3_nxt;
      len_hi_r    <= len_hi_nxt;
      skip_r      <= skip_nxt;
      quant_r     <= quant_nxt;
      huff_r      <= huff_nxt;
      frame_r     <= frame_nxt;
      scan_r      <= scan_nxt;
      data_r      <= data_nxt;
      app1_r      <= app1_nxt;
      app1_seen_r <= app1_seen_nxt;
      scan_seen_r <= scan_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_last_byte) begin
      size_r        <= clamp(pos_nxt);
      next_r        <= in_write_next ? clamp(pos_nxt) : 24'd0;
      oquant_r      <= clamp(quant_nxt);
      ohuff_r       <= clamp(huff_nxt);
      oframe_r      <= clamp(frame_nxt);
      oscan_r       <= clamp(scan_nxt);
      odata_r       <= clamp(data_nxt);
      oapp1_r       <= clamp(app1_nxt);
      oapp1_found_r <= app1_seen_nxt;
      oscan_found_r <= scan_seen_nxt;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_frame_size           = size_r;
  assign out_next_field_offset    = next_r;
  assign out_quant_table_offset   = oquant_r;
  assign out_huffman_table_offset = ohuff_r;
  assign out_frame_header_offset  = oframe_r;
  assign out_scan_header_offset   = oscan_r;
  assign out_scan_data_offset     = odata_r;
  assign out_app1_payload_offset  = oapp1_r;
  assign out_app1_found           = oapp1_found_r;
  assign out_scan_found           = oscan_found_r;

endmodule

// ----- src/jmsi_checker.sv -----
// port-level checks for the jpeg marker segment indexer, bound to the top level
module jmsi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] out_frame_size,
  input logic [23:0] out_next_field_offset,
  input logic [23:0] out_quant_table_offset,
  input logic [23:0] out_scan_data_offset,
  input logic [23:0] out_app1_payload_offset,
  input logic        out_app1_found,
  input logic        out_scan_found
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("record dropped while stalled");

  a_next_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_next_field_offset == 24'd0 ||
                   out_next_field_offset == out_frame_size))
    else $error("next field offset neither zero nor frame size");

  a_scan_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_scan_found |-> out_scan_data_offset == 24'd0)
    else $error("scan data offset without scan");

  a_app1: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_app1_found |-> out_app1_payload_offset == 24'd0)
    else $error("app1 offset without app1 marker");

  a_quant_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_quant_table_offset <= out_frame_size)
    else $error("quant table offset beyond frame");

endmodule

bind jpeg_marker_segment_indexer_top jmsi_checker u_jmsi_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .out_valid               (out_valid),
  .out_stall               (out_stall),
  .out_frame_size          (out_frame_size),
  .out_next_field_offset   (out_next_field_offset),
  .out_quant_table_offset  (out_quant_table_offset),
  .out_scan_data_offset    (out_scan_data_offset),
  .out_app1_payload_offset (out_app1_payload_offset),
  .out_app1_found          (out_app1_found),
  .out_scan_found          (out_scan_found)
);

// ----- dv/tb_jpeg_marker_segment_indexer_top.sv -----
// testbench for jpeg_marker_segment_indexer_top: directed table, then predicted random frames
module tb_jpeg_marker_segment_indexer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jmsi_pkg::*;

  localparam int PB = 24;
  localparam logic [PB-1:0] POS_MAX = '1;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [23:0] frame_size;
    logic [23:0] next_off;
    logic [23:0] quant_off;
    logic [23:0] huff_off;
    logic [23:0] frame_hdr_off;
    logic [23:0] scan_hdr_off;
    logic [23:0] scan_data_off;
    logic [23:0] app1_off;
    logic        app1_found;
    logic        scan_found;
  } rec_t;

  localparam rec_t NO_REC = '{default: '0};

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       wnext;
    bit         typed;
    rec_t       want;
  } dir_row_t;

  typedef enum {FORM_WELL, FORM_CUT, FORM_NOISE} form_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        in_write_next = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] out_frame_size;
  logic [23:0] out_next_field_offset;
  logic [23:0] out_quant_table_offset;
  logic [23:0] out_huffman_table_offset;
  logic [23:0] out_frame_header_offset;
  logic [23:0] out_scan_header_offset;
  logic [23:0] out_scan_data_offset;
  logic [23:0] out_app1_payload_offset;
  logic        out_app1_found;
  logic        out_scan_found;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  jpeg_marker_segment_indexer_top dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_data_byte             (in_data_byte),
    .in_last_byte             (in_last_byte),
    .in_write_next            (in_write_next),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_frame_size           (out_frame_size),
    .out_next_field_offset    (out_next_field_offset),
    .out_quant_table_offset   (out_quant_table_offset),
    .out_huffman_table_offset (out_huffman_table_offset),
    .out_frame_header_offset  (out_frame_header_offset),
    .out_scan_header_offset   (out_scan_header_offset),
    .out_scan_data_offset     (out_scan_data_offset),
    .out_app1_payload_offset  (out_app1_payload_offset),
    .out_app1_found           (out_app1_found),
    .out_scan_found           (out_scan_found),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_data                 (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic          kludge;
  logic [PB-1:0] scan_pos;
  phase_t        phase;
  kind_t         pend_kind;
  logic [PB-1:0] mark_pos;
  logic [7:0]    len_hi;
  logic [15:0]   skip_left;
  logic [PB-1:0] off_quant, off_huff, off_frame, off_scan, off_data, off_app1;
  logic          app1_seen, sos_seen;

  rec_t     rec_q[$];
  rec_t     got_rec, want_rec;
  logic [7:0] frame_q[$];
  dir_row_t dir_tab[28];

  int n_errors = 0;
  int quiet_cycles = 0;
  int src_idle_pct = 0;
  int rcv_idle_pct = 0;

  function automatic logic [PB-1:0] pos_add(input logic [PB-1:0] a, input logic [16:0] b);
    logic [PB+16:0] s;
    s = a + b;
    return (s > POS_MAX) ? POS_MAX : s[PB-1:0];
  endfunction

  function automatic kind_t code_kind(input logic [7:0] c);
    case (c)
      CODE_DHT:  return KIND_DHT;
      CODE_DQT:  return KIND_DQT;
      CODE_SOF0: return KIND_SOF0;
      CODE_SOS:  return KIND_SOS;
      CODE_APP1: return KIND_APP1;
      default:   return KIND_NONE;
    endcase
  endfunction

  task automatic clear_frame();
    scan_pos = '0;
    phase = PH_HUNT;
    pend_kind = KIND_NONE;
    mark_pos = '0;
    len_hi = '0;
    skip_left = '0;
    off_quant = '0;
    off_huff = '0;
    off_frame = '0;
    off_scan = '0;
    off_data = '0;
    off_app1 = '0;
    app1_seen = 1'b0;
    sos_seen = 1'b0;
  endtask

  task automatic index_byte(input logic [7:0] b, input logic last, input logic wn,
                            output bit has_rec, output rec_t r);
    logic [PB-1:0] pos;
    logic [15:0]   seglen, skip;
    kind_t         k;
    pos = scan_pos;
    has_rec = 1'b0;
    r = NO_REC;
    case (phase)
      PH_HUNT: begin
        if (b == MARK_PREFIX) phase = PH_FILL;
      end
      PH_FILL: begin
        if (b == MARK_STUFF) begin
          phase = PH_HUNT;
        end else if (b != MARK_PREFIX) begin
          k = code_kind(b);
          pend_kind = k;
          if (k == KIND_NONE) begin
            phase = PH_HUNT;
          end else begin
            mark_pos = pos;
            case (k)
              KIND_DHT:  off_huff = pos - 1'b1;
              KIND_DQT:  off_quant = pos - 1'b1;
              KIND_SOF0: off_frame = pos - 1'b1;
              KIND_SOS:  off_scan = pos - 1'b1;
              default: begin
                off_app1 = pos_add(pos, 17'(MARK_TO_DATA));
                app1_seen = 1'b1;
              end
            endcase
            phase = PH_LEN_HI;
          end
        end
      end
      PH_LEN_HI: begin
        len_hi = b;
        phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        seglen = {len_hi, b};
        if (kludge && pend_kind != KIND_APP1) skip = seglen;
        else skip = (seglen >= 16'd2) ? seglen - 16'd2 : 16'd0;
        if (pend_kind == KIND_SOS) begin
          off_data = pos_add(pos_add(mark_pos, 17'(MARK_TO_DATA)), 17'(skip));
          sos_seen = 1'b1;
          phase = PH_STOP;
        end else begin
          skip_left = skip;
          phase = (skip != 16'd0) ? PH_SKIP : PH_HUNT;
        end
      end
      PH_SKIP: begin
        if (skip_left <= 16'd1) begin
          skip_left = '0;
          phase = PH_HUNT;
        end else begin
          skip_left = skip_left - 16'd1;
        end
      end
      default: ;
    endcase
    scan_pos = pos_add(pos, 17'(1));
    if (last) begin
      r.frame_size = scan_pos;
      r.next_off = wn ? scan_pos : '0;
      r.quant_off = off_quant;
      r.huff_off = off_huff;
      r.frame_hdr_off = off_frame;
      r.scan_hdr_off = off_scan;
      r.scan_data_off = off_data;
      r.app1_off = off_app1;
      r.app1_found = app1_seen;
      r.scan_found = sos_seen;
      has_rec = 1'b1;
      clear_frame();
    end
  endtask

  task automatic check_field(input string what, input logic [23:0] e, input logic [23:0] a);
    if (a !== e) begin
      n_errors++;
      if (n_errors <= 10)
        $display("mismatch %s: expected %0h got %0h", what, e, a);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      got_rec.frame_size = out_frame_size;
      got_rec.next_off = out_next_field_offset;
      got_rec.quant_off = out_quant_table_offset;
      got_rec.huff_off = out_huffman_table_offset;
      got_rec.frame_hdr_off = out_frame_header_offset;
      got_rec.scan_hdr_off = out_scan_header_offset;
      got_rec.scan_data_off = out_scan_data_offset;
      got_rec.app1_off = out_app1_payload_offset;
      got_rec.app1_found = out_app1_found;
      got_rec.scan_found = out_scan_found;
      if (rec_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected record: frame_size %0h", got_rec.frame_size);
      end else begin
        want_rec = rec_q.pop_front();
        check_field("frame_size", want_rec.frame_size, got_rec.frame_size);
        check_field("next_field_offset", want_rec.next_off, got_rec.next_off);
        check_field("quant_table_offset", want_rec.quant_off, got_rec.quant_off);
        check_field("huffman_table_offset", want_rec.huff_off, got_rec.huff_off);
        check_field("frame_header_offset", want_rec.frame_hdr_off, got_rec.frame_hdr_off);
        check_field("scan_header_offset", want_rec.scan_hdr_off, got_rec.scan_hdr_off);
        check_field("scan_data_offset", want_rec.scan_data_off, got_rec.scan_data_off);
        check_field("app1_payload_offset", want_rec.app1_off, got_rec.app1_off);
        check_field("app1_found", 24'(want_rec.app1_found), 24'(got_rec.app1_found));
        check_field("scan_found", 24'(want_rec.scan_found), 24'(got_rec.scan_found));
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0) ||
        (cfg_valid === 1'b1 && cfg_ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_word(input logic [7:0] d, input logic l, input logic w,
                           input bit typed, input rec_t want);
    bit   has;
    rec_t r;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= l;
    in_write_next <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    index_byte(d, l, w, has, r);
    if (has) rec_q.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (rec_q.size() != 0);
  endtask

  task automatic write_mode(input logic m);
    drain();
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    kludge = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int seg_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(0, 1);
    if (r == 1) return $urandom_range(2, 300);
    return $urandom_range(2, 12);
  endfunction

  task automatic push_segment(input logic [7:0] code, input int len);
    int n;
    frame_q.push_back(MARK_PREFIX);
    frame_q.push_back(code);
    frame_q.push_back(8'(len >> 8));
    frame_q.push_back(8'(len));
    if (kludge && code != CODE_APP1) n = len;
    else n = (len >= 2) ? len - 2 : 0;
    repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic make_frame(input form_t f);
    int n, cut;
    logic [7:0] c;
    frame_q.delete();
    if (f == FORM_NOISE) begin
      n = $urandom_range(1, 24);
      repeat (n)
        frame_q.push_back(($urandom_range(0, 9) < 3) ? MARK_PREFIX : 8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0) begin
      frame_q.push_back(MARK_PREFIX);
      frame_q.push_back(8'hD8);
    end
    n = $urandom_range(0, 5);
    repeat (n) begin
      case ($urandom_range(0, 6))
        0: push_segment(CODE_DHT, seg_len());
        1: push_segment(CODE_DQT, seg_len());
        2: push_segment(CODE_SOF0, seg_len());
        3: push_segment(CODE_APP1, seg_len());
        4: begin
          do c = 8'($urandom_range(1, 254));
          while (code_kind(c) != KIND_NONE);
          frame_q.push_back(MARK_PREFIX);
          frame_q.push_back(c);
        end
        5: begin
          frame_q.push_back(MARK_PREFIX);
          frame_q.push_back(MARK_STUFF);
        end
        default: frame_q.push_back(MARK_PREFIX);
      endcase
    end
    push_segment(CODE_SOS, seg_len());
    n = $urandom_range(0, 12);
    repeat (n + 1) frame_q.push_back(8'($urandom_range(0, 255)));
    if (f == FORM_CUT) begin
      cut = $urandom_range(1, frame_q.size());
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
  endtask

  task automatic send_frame();
    foreach (frame_q[i])
      send_word(frame_q[i], i == frame_q.size() - 1, 1'($urandom_range(0, 1)), 1'b0, NO_REC);
  endtask

  task automatic run_random(input int n_items, input int n_frames);
    int    items, frames, pick;
    form_t f;
    items = 0;
    frames = 0;
    while (items < n_items || frames < n_frames) begin
      pick = $urandom_range(0, 99);
      f = (pick < 70) ? FORM_WELL : (pick < 85) ? FORM_CUT : FORM_NOISE;
      make_frame(f);
      items += frame_q.size();
      send_frame();
      frames++;
      if ($urandom_range(0, 9) == 0) drain();
    end
  endtask

  initial begin
    kludge = 1'b0;
    clear_frame();
    dir_tab = '{
      // single byte frame right after reset
      '{8'hFF, 1'b1, 1'b1, 1'b1, '{frame_size: 24'd1, next_off: 24'd1, default: '0}},
      // fill, app1, dqt with skip, stuffing, short dht length, sos, data
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'hE1, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'h02, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'hDB, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'h03, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'hAA, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'hC4, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'h01, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'hDA, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'h02, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'h7F, 1'b1, 1'b1, 1'b0, NO_REC},
      // other marker, sof0, largest length, early end before the skip
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'hD8, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'hC0, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_REC},
      '{8'hFF, 1'b1, 1'b0, 1'b1, '{frame_size: 24'd6, frame_hdr_off: 24'd2, default: '0}}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_mode(1'b0);
    src_idle_pct = 31;
    rcv_idle_pct = 74;
    foreach (dir_tab[i])
      send_word(dir_tab[i].data, dir_tab[i].last, dir_tab[i].wnext,
                dir_tab[i].typed, dir_tab[i].want);

    write_mode(1'b1);
    run_random(270, 6);

    src_idle_pct = 74;
    rcv_idle_pct = 31;
    write_mode(1'b0);
    run_random(270, 6);

    src_idle_pct = 0;
    rcv_idle_pct = 0;
    write_mode(1'b1);
    // one longer skip
    frame_q.delete();
    push_segment(CODE_DQT, 40);
    push_segment(CODE_SOS, 2);
    frame_q.push_back(8'($urandom_range(0, 255)));
    send_frame();
    run_random(270, 6);

    drain();
    repeat (8) @(negedge clk);
    n_errors += rec_q.size();
    if (n_errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
